### hw/rtl/keyed_override_table_top_assert.svh
// assertion macros for the keyed override table
`ifndef KEYED_OVERRIDE_TABLE_TOP_ASSERT_SVH
`define KEYED_OVERRIDE_TABLE_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define KOT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define KOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/kot_pkg.sv
// package for the keyed override table: widths, codes and defaults
package kot_pkg;

  localparam int unsigned TableCapacity = 64;
  localparam int unsigned HookCount     = 16;
  localparam int unsigned KeyW          = 64;

  typedef enum logic [2:0] {
    ACT_SET       = 3'd0,
    ACT_GET       = 3'd1,
    ACT_REMOVE    = 3'd2,
    ACT_SET_DEF   = 3'd3,
    ACT_GET_DEF   = 3'd4,
    ACT_QUERY     = 3'd5,
    ACT_CLR_HOOK  = 3'd6,
    ACT_CLR_ALL   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_HOOK = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  hook;
    logic [31:0] object_count;
    logic [15:0] object_index;
    logic [7:0]  object_type;
    logic [31:0] value_bits;
    logic        default_present;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        hook_enabled;
  } rsp_t;

endpackage

### hw/rtl/kot_if.sv
// valid/ready channel carrying one word of a given payload type
interface kot_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/keyed_override_table_top.sv
// keyed override table: sequenced walk over an entry memory
//
// channel  dir  payload           handshake
// req      in   kot_pkg::req_t    valid/ready
// rsp      out  kot_pkg::rsp_t    valid/ready
//
// a word scans the entries one at a time through S_RD and S_CMP, then passes S_WR (set
// only), S_FIN and S_OUT; remove after the hit and clear hook add an S_MOVE step per entry,
// as they compact the key memory through the single memory read port.
// reset clears the count and hook settings at once; no clearing pass.
// a held result blocks the next word until taken.
module keyed_override_table_top #(
  parameter int unsigned TABLE_CAPACITY = kot_pkg::TableCapacity,
  parameter int unsigned HOOK_COUNT     = kot_pkg::HookCount
) (
  input  logic clk_i,
  input  logic rst_ni,
  kot_if.sink   req_i,
  kot_if.source rsp_o
);
  import kot_pkg::*;

  localparam int unsigned AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
  localparam int unsigned CW = $clog2(TABLE_CAPACITY + 1);
  localparam int unsigned HW = (HOOK_COUNT > 1) ? $clog2(HOOK_COUNT) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // memories
  logic [KeyW-1:0] key_mem [TABLE_CAPACITY];
  logic [31:0]     val_mem [TABLE_CAPACITY];

  logic [2:0]      state_q;
  req_t            req_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   rd_q;      // read pointer
  logic [CW-1:0]   wr_q;      // compaction write pointer
  logic [CW-1:0]   pos_q;     // found position, count when absent
  logic            found_q;
  logic            hook_has_q;
  logic [KeyW-1:0] rkey_q;
  logic [31:0]     rval_q;
  logic            mwe;
  logic [AW-1:0]   maddr;
  logic [KeyW-1:0] mkey;
  logic [31:0]     mval;
  logic [HOOK_COUNT-1:0] en_q, fix_q;
  logic [31:0]     defv_q [HOOK_COUNT];
  rsp_t            rsp_q;
  logic            rsp_v_q;

  logic [KeyW-1:0] key_w;
  logic            hook_ok;
  logic [HW-1:0]   hidx;
  logic            key_hit, hook_hit;
  logic            hold_rd;

  assign key_w   = {req_q.hook, req_q.object_type, req_q.object_index, req_q.object_count};
  assign hook_ok = ({24'd0, req_q.hook} < 32'(HOOK_COUNT));
  assign hidx    = req_q.hook[HW-1:0];
  assign key_hit  = (rkey_q == key_w);
  assign hook_hit = (rkey_q[63:56] == req_q.hook);
  // keep the hit entry addressed so its value is read back
  assign hold_rd  = key_hit && (req_q.action == ACT_SET || req_q.action == ACT_GET);

  assign req_i.ready   = (state_q == S_IDLE) && !rsp_v_q;
  assign rsp_o.valid   = rsp_v_q;
  assign rsp_o.payload = rsp_q;

  // memory port: registered read, single write
  always_ff @(posedge clk_i) begin
    if (mwe) begin
      key_mem[maddr] <= mkey;
      val_mem[maddr] <= mval;
    end
    rkey_q <= key_mem[rd_q[AW-1:0]];
    rval_q <= val_mem[rd_q[AW-1:0]];
  end

  // write port selection
  always_comb begin
    mwe   = 1'b0;
    maddr = wr_q[AW-1:0];
    mkey  = rkey_q;
    mval  = rval_q;
    if (state_q == S_MOVE) begin
      mwe = (req_q.action == ACT_CLR_HOOK) ? !hook_hit : 1'b1;
    end else if (state_q == S_WR) begin
      mwe   = 1'b1;
      maddr = pos_q[AW-1:0];
      mkey  = key_w;
      mval  = req_q.value_bits;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      en_q    <= '0;
      fix_q   <= '0;
      rsp_v_q <= 1'b0;
      rd_q    <= '0;
      wr_q    <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
      hook_has_q <= 1'b0;
      for (int h = 0; h < HOOK_COUNT; h++) defv_q[h] <= '0;
    end else begin
      if (rsp_v_q && rsp_o.ready) rsp_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            state_q    <= S_RD;
            req_q      <= req_i.payload;
            rd_q       <= '0;
            wr_q       <= '0;
            pos_q      <= count_q;
            found_q    <= 1'b0;
            hook_has_q <= 1'b0;
          end
        end
        // check whether the scan is over, memory read issued for rd_q
        S_RD: begin
          if (req_q.action == ACT_CLR_ALL || !hook_ok ||
              req_q.action == ACT_QUERY || req_q.action == ACT_GET_DEF ||
              rd_q >= count_q ||
              (found_q && req_q.action != ACT_REMOVE) ||
              (req_q.action == ACT_SET_DEF && hook_has_q)) begin
            state_q <= (req_q.action == ACT_SET && hook_ok && (found_q ||
                        count_q < CW'(TABLE_CAPACITY))) ? S_WR : S_FIN;
          end else begin
            state_q <= S_CMP;
          end
        end
        // compare one entry; after a removal hit or for clear hook, shift down
        S_CMP: begin
          if (req_q.action == ACT_CLR_HOOK || (req_q.action == ACT_REMOVE && found_q)) begin
            rd_q    <= rd_q + 1'b1;
            state_q <= S_MOVE;
          end else begin
            if (!(req_q.action != ACT_SET_DEF && hold_rd)) rd_q <= rd_q + 1'b1;
            state_q <= S_RD;
            if (req_q.action == ACT_SET_DEF) begin
              if (hook_hit) hook_has_q <= 1'b1;
            end else if (key_hit) begin
              found_q <= 1'b1;
              pos_q   <= rd_q;
              if (req_q.action == ACT_REMOVE) wr_q <= rd_q;
            end else if (req_q.action == ACT_REMOVE && hook_hit) begin
              hook_has_q <= 1'b1;
            end
          end
        end
        S_MOVE: begin
          state_q <= S_RD;
          if (req_q.action == ACT_CLR_HOOK) begin
            if (!hook_hit) wr_q <= wr_q + 1'b1;
          end else begin
            wr_q <= wr_q + 1'b1;
            if (hook_hit) hook_has_q <= 1'b1;
          end
        end
        S_WR: state_q <= S_FIN;
        // commit settings and form the result
        S_FIN: begin
          state_q <= S_OUT;
          rsp_q.hook_enabled <= 1'b0;
          if (req_q.action == ACT_CLR_ALL) begin
            count_q <= '0;
            en_q    <= '0;
            fix_q   <= '0;
            for (int h = 0; h < HOOK_COUNT; h++) defv_q[h] <= '0;
            rsp_q.status     <= ST_OK;
            rsp_q.read_value <= '0;
          end else if (!hook_ok) begin
            rsp_q.status     <= ST_BAD_HOOK;
            rsp_q.read_value <= '0;
          end else begin
            case (req_q.action)
              ACT_SET: begin
                rsp_q.read_value <= '0;
                if (found_q || count_q < CW'(TABLE_CAPACITY)) begin
                  if (!found_q) count_q <= count_q + 1'b1;
                  en_q[hidx]   <= 1'b1;
                  rsp_q.status <= ST_OK;
                end else begin
                  rsp_q.status <= ST_FULL;
                end
              end
              ACT_GET: begin
                if (found_q) begin
                  rsp_q.status     <= ST_OK;
                  rsp_q.read_value <= rval_q;
                end else begin
                  rsp_q.status     <= ST_MISS;
                  rsp_q.read_value <= '0;
                end
              end
              ACT_REMOVE: begin
                rsp_q.read_value <= '0;
                if (found_q) begin
                  count_q      <= count_q - 1'b1;
                  en_q[hidx]   <= hook_has_q || fix_q[hidx];
                  rsp_q.status <= ST_OK;
                end else begin
                  rsp_q.status <= ST_MISS;
                end
              end
              ACT_SET_DEF: begin
                fix_q[hidx]  <= req_q.default_present;
                defv_q[hidx] <= req_q.default_present ? req_q.value_bits : '0;
                en_q[hidx]   <= req_q.default_present || hook_has_q;
                rsp_q.status     <= ST_OK;
                rsp_q.read_value <= '0;
              end
              ACT_GET_DEF: begin
                if (fix_q[hidx]) begin
                  rsp_q.status     <= ST_OK;
                  rsp_q.read_value <= defv_q[hidx];
                end else begin
                  rsp_q.status     <= ST_MISS;
                  rsp_q.read_value <= '0;
                end
              end
              ACT_CLR_HOOK: begin
                count_q      <= wr_q;
                en_q[hidx]   <= 1'b0;
                fix_q[hidx]  <= 1'b0;
                defv_q[hidx] <= '0;
                rsp_q.status     <= ST_OK;
                rsp_q.read_value <= '0;
              end
              default: begin
                rsp_q.status     <= ST_OK;
                rsp_q.read_value <= '0;
              end
            endcase
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
          rsp_v_q <= 1'b1;
          if (req_q.action != ACT_CLR_ALL && hook_ok) rsp_q.hook_enabled <= en_q[hidx];
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "keyed_override_table_top_assert.svh"

  `KOT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(TABLE_CAPACITY), "entry count over capacity")
  `KOT_ASSERT_IMP(a_no_in_busy, state_q != S_IDLE, !req_i.ready, "ready while busy")
  `KOT_ASSERT_NEXT(a_out_after, state_q == S_OUT, rsp_v_q, "result not presented")
  `KOT_ASSERT_IMP(a_wr_le_rd, state_q == S_MOVE, wr_q < rd_q, "compaction overtook scan")

endmodule
